// ===== rtl/core/sdoc_pkg.sv =====
`timescale 1ns / 1ps

package sdoc_pkg;

   // action codes carried in req_tuser
   typedef enum logic [1:0] {
      ACT_START_WRITE = 2'd0,
      ACT_START_READ  = 2'd1,
      ACT_RX_FRAME    = 2'd2,
      ACT_TICK        = 2'd3
   } action_type;

   // result kinds carried in rsp_tuser
   localparam logic KIND_TX_REQUEST = 1'b0;
   localparam logic KIND_COMPLETE   = 1'b1;

   // completion status
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_GAVE_UP = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_NODE_ID       = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [1:0] CSR_MAX_ATTEMPTS  = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // csr reset values
   localparam logic [6:0] NODE_ID_RST       = 7'd1;
   localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;
   localparam logic [3:0] MAX_ATTEMPTS_RST  = 4'd5;

   // identifiers and command bytes
   localparam logic [10:0] ID_REQ_BASE   = 11'h600;
   localparam logic [10:0] ID_RESP_BASE  = 11'h580;
   localparam logic [7:0]  CMD_WRITE_REQ = 8'h22;
   localparam logic [7:0]  CMD_READ_REQ  = 8'h40;
   localparam logic [7:0]  CMD_WRITE_ACK = 8'h60;
   localparam logic [7:0]  CMD_READ_ACK4 = 8'h43;
   localparam logic [7:0]  CMD_READ_ACK3 = 8'h47;
   localparam logic [7:0]  CMD_READ_ACK2 = 8'h4B;
   localparam logic [7:0]  CMD_READ_ACK1 = 8'h4F;

   // word widths
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 112;

   // request word: obj_index, obj_subindex, write_value, rx_id, rx_low, rx_high
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] rx_high;
      logic [31:0] rx_low;
      logic [10:0] rx_id;
      logic [31:0] write_value;
      logic [7:0]  obj_subindex;
      logic [15:0] obj_index;
   } req_word_type;

   // result word: tx_id, tx_low, tx_high, status, read_value
   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] read_value;
      logic        status;
      logic [31:0] tx_high;
      logic [31:0] tx_low;
      logic [10:0] tx_id;
   } rsp_word_type;

endpackage

// ===== rtl/core/sdo_expedited_client.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake            tdata / tuser
// req      in   req_tvalid/tready    index, subindex, value, rx_id, rx_low, rx_high / action
// rsp      out  rsp_tvalid/tready    tx_id, tx_low, tx_high, status, read_value / kind
// csr      in   csr_we               csr_index, csr_wdata (no read-back)
//
// one word per cycle while the rsp side is not stalled: a word is held in the input
// register, decoded against the held transfer and registered into the result register.
// reset is synchronous and leaves the block idle with csr defaults loaded.
// a stalled rsp side holds both registers; req_tready drops only when both are full.

module sdo_expedited_client (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // obj_index, obj_subindex, write_value, rx_id, rx_low, rx_high
   input  logic [sdoc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                        req_tuser,   // action
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tx_id, tx_low, tx_high, status, read_value
   output logic [sdoc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,   // kind
   // register writes
   input  logic                              csr_we,
   input  logic [sdoc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sdoc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic [6:0] node_id_ff;
   logic [7:0] timeout_ticks_ff;
   logic [3:0] max_attempts_ff;

   // input stage
   logic                      s1_valid_ff, s1_valid_in;
   sdoc_pkg::action_type      s1_action_ff;
   sdoc_pkg::req_word_type    s1_word_ff;

   // transfer state
   logic        busy_ff, busy_in;
   logic        is_read_ff, is_read_in;
   logic [15:0] held_index_ff, held_index_in;
   logic [7:0]  held_subindex_ff, held_subindex_in;
   logic [31:0] held_value_ff, held_value_in;
   logic [3:0]  attempts_ff, attempts_in;
   logic [7:0]  ticks_ff, ticks_in;

   // result stage
   logic                   out_valid_ff, out_valid_in;
   logic                   out_kind_ff, out_kind_in;
   sdoc_pkg::rsp_word_type out_word_ff, out_word_in;

   logic       advance;
   logic       is_start;
   logic       emit;
   logic       send_req;
   logic       id_match;
   logic       obj_match;
   logic       cmd_good;
   logic [7:0] rx_cmd;
   logic [7:0] tick_next;

   // stage control
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = out_kind_ff;

   always_comb begin
      s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff       <= sdoc_pkg::NODE_ID_RST;
         timeout_ticks_ff <= sdoc_pkg::TIMEOUT_TICKS_RST;
         max_attempts_ff  <= sdoc_pkg::MAX_ATTEMPTS_RST;
      end else if (csr_we) begin
         case (csr_index)
            sdoc_pkg::CSR_NODE_ID:       node_id_ff       <= csr_wdata[6:0];
            sdoc_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            sdoc_pkg::CSR_MAX_ATTEMPTS:  max_attempts_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // response checks
   assign rx_cmd    = s1_word_ff.rx_low[7:0];
   assign id_match  = s1_word_ff.rx_id == (sdoc_pkg::ID_RESP_BASE + {4'd0, node_id_ff});
   assign obj_match = (s1_word_ff.rx_low[23:8] == held_index_ff) &&
                      (s1_word_ff.rx_low[31:24] == held_subindex_ff);
   assign is_start  = (s1_action_ff == sdoc_pkg::ACT_START_WRITE) ||
                      (s1_action_ff == sdoc_pkg::ACT_START_READ);
   assign tick_next = ticks_ff + 8'd1;

   always_comb begin
      if (is_read_ff) begin
         cmd_good = rx_cmd inside {sdoc_pkg::CMD_READ_ACK4, sdoc_pkg::CMD_READ_ACK3,
                                   sdoc_pkg::CMD_READ_ACK2, sdoc_pkg::CMD_READ_ACK1};
      end else begin
         cmd_good = rx_cmd == sdoc_pkg::CMD_WRITE_ACK;
      end
   end

   // next transfer state and result word
   always_comb begin
      logic retry;
      retry            = 1'b0;
      busy_in          = busy_ff;
      is_read_in       = is_read_ff;
      held_index_in    = held_index_ff;
      held_subindex_in = held_subindex_ff;
      held_value_in    = held_value_ff;
      attempts_in      = attempts_ff;
      ticks_in         = ticks_ff;
      emit             = 1'b0;
      send_req         = 1'b0;
      out_kind_in      = sdoc_pkg::KIND_COMPLETE;
      out_word_in      = '0;

      if (is_start) begin
         is_read_in       = s1_action_ff == sdoc_pkg::ACT_START_READ;
         held_index_in    = s1_word_ff.obj_index;
         held_subindex_in = s1_word_ff.obj_subindex;
         held_value_in    = is_read_in ? 32'd0 : s1_word_ff.write_value;
         busy_in          = 1'b1;
         attempts_in      = 4'd1;
         send_req         = 1'b1;
      end else if (busy_ff) begin
         case (s1_action_ff)
            sdoc_pkg::ACT_RX_FRAME: begin
               if (id_match && obj_match && cmd_good) begin
                  busy_in                = 1'b0;
                  ticks_in               = 8'd0;
                  emit                   = 1'b1;
                  out_word_in.status     = sdoc_pkg::STATUS_OK;
                  out_word_in.read_value = is_read_ff ? s1_word_ff.rx_high : 32'd0;
               end else begin
                  retry = 1'b1;
               end
            end
            sdoc_pkg::ACT_TICK: begin
               ticks_in = tick_next;
               retry    = (tick_next >= timeout_ticks_ff) || (tick_next == 8'd0);
            end
            default: ;
         endcase

         // resend or give up
         if (retry) begin
            if (attempts_ff < max_attempts_ff) begin
               attempts_in = attempts_ff + 4'd1;
               send_req    = 1'b1;
            end else begin
               busy_in            = 1'b0;
               ticks_in           = 8'd0;
               emit               = 1'b1;
               out_word_in.status = sdoc_pkg::STATUS_GAVE_UP;
            end
         end
      end

      // request frame from the updated hold registers
      if (send_req) begin
         ticks_in            = 8'd0;
         emit                = 1'b1;
         out_kind_in         = sdoc_pkg::KIND_TX_REQUEST;
         out_word_in.tx_id   = sdoc_pkg::ID_REQ_BASE + {4'd0, node_id_ff};
         out_word_in.tx_low  = {held_subindex_in, held_index_in,
                                is_read_in ? sdoc_pkg::CMD_READ_REQ : sdoc_pkg::CMD_WRITE_REQ};
         out_word_in.tx_high = is_read_in ? 32'd0 : held_value_in;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
         attempts_ff  <= 4'd0;
         ticks_ff     <= 8'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            busy_ff     <= busy_in;
            is_read_ff  <= is_read_in;
            attempts_ff <= attempts_in;
            ticks_ff    <= ticks_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= sdoc_pkg::action_type'(req_tuser);
         s1_word_ff   <= req_tdata;
      end
      if (advance) begin
         held_index_ff    <= held_index_in;
         held_subindex_ff <= held_subindex_in;
         held_value_ff    <= held_value_in;
         out_kind_ff      <= out_kind_in;
         out_word_ff      <= out_word_in;
      end
   end

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && out_valid_ff))
      else $error("req stalled while a stage is free");

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (advance && is_start) |=> (busy_ff && rsp_tvalid && !rsp_tuser))
      else $error("start did not open a transfer with a request word");

   a_busy_fall_completes: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy_ff) && !$past(reset)) |-> (rsp_tvalid && rsp_tuser))
      else $error("transfer ended without a completion word");

   a_attempts_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (attempts_ff != 4'd0))
      else $error("busy with no attempt counted");

endmodule

// ===== verif/tb_sdo_expedited_client.sv =====
`timescale 1ns / 1ps

module tb_sdo_expedited_client;

   localparam int WORDS_PER_PHASE = 250;
   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 8;

   // one result as the client should emit it
   typedef struct packed {
      logic        kind;
      logic [10:0] tx_id;
      logic [31:0] tx_low;
      logic [31:0] tx_high;
      logic        status;
      logic [31:0] read_value;
   } client_out_type;

   // one request word waiting for the driver
   typedef struct packed {
      sdoc_pkg::action_type   action;
      sdoc_pkg::req_word_type word;
   } req_item_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [sdoc_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic [1:0]                       req_tuser = sdoc_pkg::ACT_TICK;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sdoc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_we = 1'b0;
   logic [sdoc_pkg::CSR_INDEX_W-1:0] csr_index = sdoc_pkg::CSR_NODE_ID;
   logic [sdoc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   sdo_expedited_client dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   req_item_type   pending_words[$];
   client_out_type awaited_results[$];

   // client state as predicted
   logic        cl_busy;
   logic        cl_read;
   logic [15:0] cl_index;
   logic [7:0]  cl_sub;
   logic [31:0] cl_value;
   logic [3:0]  cl_tries;
   logic [7:0]  cl_ticks;
   logic [6:0]  cl_node;
   logic [7:0]  cl_timeout;
   logic [3:0]  cl_limit;

   // settings as the stimulus side knows them
   int gen_node;
   int gen_timeout;
   int gen_limit;
   int gen_count = 0;

   int fail_count   = 0;
   int words_in     = 0;
   int results_seen = 0;
   int done_ok      = 0;
   int gave_up      = 0;
   int settings     = 0;
   int idle_cycles  = 0;

   // accept counts already acted on by the driving blocks
   int req_done    = 0;
   bit req_holding = 1'b0;
   bit req_steady  = 1'b0;
   int req_gap     = 0;
   int rsp_done    = 0;
   bit rsp_steady  = 1'b0;
   int rsp_stall   = 0;
   bit fired;

   req_item_type           next_word;
   client_out_type         want;
   client_out_type         predicted;
   sdoc_pkg::rsp_word_type seen;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // request frame for the held transfer, restarts the timeout count
   function automatic client_out_type request_frame();
      client_out_type r;
      r = '0;
      r.kind    = sdoc_pkg::KIND_TX_REQUEST;
      r.tx_id   = sdoc_pkg::ID_REQ_BASE + {4'd0, cl_node};
      r.tx_low  = {cl_sub, cl_index, cl_read ? sdoc_pkg::CMD_READ_REQ : sdoc_pkg::CMD_WRITE_REQ};
      r.tx_high = cl_read ? 32'd0 : cl_value;
      cl_ticks  = 8'd0;
      return r;
   endfunction

   function automatic client_out_type resend_or_give_up();
      client_out_type r;
      if (cl_tries < cl_limit) begin
         cl_tries = cl_tries + 4'd1;
         return request_frame();
      end
      cl_busy  = 1'b0;
      cl_ticks = 8'd0;
      r = '0;
      r.kind   = sdoc_pkg::KIND_COMPLETE;
      r.status = sdoc_pkg::STATUS_GAVE_UP;
      return r;
   endfunction

   // advances the client by one word, returns 1 when a result is due
   function automatic bit predict_client_output(input sdoc_pkg::action_type act,
                                                input sdoc_pkg::req_word_type w,
                                                output client_out_type res);
      logic [7:0] cmd;
      bit         addressed;
      bit         cmd_ok;
      res = '0;
      if (act == sdoc_pkg::ACT_START_WRITE || act == sdoc_pkg::ACT_START_READ) begin
         cl_read  = (act == sdoc_pkg::ACT_START_READ);
         cl_index = w.obj_index;
         cl_sub   = w.obj_subindex;
         cl_value = cl_read ? 32'd0 : w.write_value;
         cl_busy  = 1'b1;
         cl_tries = 4'd1;
         res = request_frame();
         return 1'b1;
      end
      if (!cl_busy)
         return 1'b0;
      if (act == sdoc_pkg::ACT_RX_FRAME) begin
         cmd = w.rx_low[7:0];
         addressed = (w.rx_id == sdoc_pkg::ID_RESP_BASE + {4'd0, cl_node}) &&
                     (w.rx_low[23:8] == cl_index) && (w.rx_low[31:24] == cl_sub);
         if (cl_read)
            cmd_ok = (cmd == sdoc_pkg::CMD_READ_ACK4) || (cmd == sdoc_pkg::CMD_READ_ACK3) ||
                     (cmd == sdoc_pkg::CMD_READ_ACK2) || (cmd == sdoc_pkg::CMD_READ_ACK1);
         else
            cmd_ok = (cmd == sdoc_pkg::CMD_WRITE_ACK);
         if (addressed && cmd_ok) begin
            cl_busy  = 1'b0;
            cl_ticks = 8'd0;
            res.kind       = sdoc_pkg::KIND_COMPLETE;
            res.status     = sdoc_pkg::STATUS_OK;
            res.read_value = cl_read ? w.rx_high : 32'd0;
            return 1'b1;
         end
         res = resend_or_give_up();
         return 1'b1;
      end
      // tick: a zero timeout behaves like one
      cl_ticks = cl_ticks + 8'd1;
      if (cl_ticks >= cl_timeout || cl_ticks == 8'd0) begin
         res = resend_or_give_up();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s mismatch: expected %h, got %h", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: register writes, accepted words and results
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      fired = 1'b0;
      if (reset) begin
         cl_busy    = 1'b0;
         cl_read    = 1'b0;
         cl_index   = '0;
         cl_sub     = '0;
         cl_value   = '0;
         cl_tries   = '0;
         cl_ticks   = '0;
         cl_node    = sdoc_pkg::NODE_ID_RST;
         cl_timeout = sdoc_pkg::TIMEOUT_TICKS_RST;
         cl_limit   = sdoc_pkg::MAX_ATTEMPTS_RST;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sdoc_pkg::CSR_NODE_ID:       cl_node = csr_wdata[6:0];
               sdoc_pkg::CSR_TIMEOUT_TICKS: cl_timeout = csr_wdata;
               sdoc_pkg::CSR_MAX_ATTEMPTS:  cl_limit = csr_wdata[3:0];
               default: ;
            endcase
         end
         // result side
         if (rsp_tvalid && rsp_tready) begin
            fired = 1'b1;
            results_seen++;
            seen = rsp_tdata;
            if (awaited_results.size() == 0) begin
               $error("result word with nothing expected: kind %0d tdata %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("tx_id", 32'(want.tx_id), 32'(seen.tx_id));
               check_field("tx_low", want.tx_low, seen.tx_low);
               check_field("tx_high", want.tx_high, seen.tx_high);
               check_field("status", 32'(want.status), 32'(seen.status));
               check_field("read_value", want.read_value, seen.read_value);
               if (want.kind == sdoc_pkg::KIND_COMPLETE) begin
                  if (want.status == sdoc_pkg::STATUS_OK)
                     done_ok++;
                  else
                     gave_up++;
               end
            end
         end
         // request side
         if (req_tvalid && req_tready) begin
            fired = 1'b1;
            words_in++;
            if (predict_client_output(sdoc_pkg::action_type'(req_tuser),
                                      sdoc_pkg::req_word_type'(req_tdata), predicted))
               awaited_results.push_back(predicted);
         end
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
   end

   // ------------------------------------------------------------------
   // driver: one word at a time from the pending queue
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (words_in != req_done) begin
            req_done    = words_in;
            req_holding = 1'b0;
            if ($urandom_range(0, 39) == 0)
               req_steady = !req_steady;
            req_gap = req_steady ? 0 : $urandom_range(0, 7);
         end
         if (!req_holding) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_tuser   <= next_word.action;
               req_tdata   <= next_word.word;
               req_holding = 1'b1;
            end
         end
         req_tvalid <= req_holding;
      end
   end

   // result side back-pressure, drawn per result
   always @(negedge clock) begin
      if (results_seen != rsp_done) begin
         rsp_done = results_seen;
         if ($urandom_range(0, 39) == 0)
            rsp_steady = !rsp_steady;
         rsp_stall = rsp_steady ? 0 : $urandom_range(0, 7);
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic sdoc_pkg::req_word_type random_word();
      sdoc_pkg::req_word_type w;
      w.pad          = '0;
      w.obj_index    = 16'($urandom);
      w.obj_subindex = 8'($urandom);
      w.write_value  = $urandom;
      w.rx_id        = 11'($urandom);
      w.rx_low       = $urandom;
      w.rx_high      = $urandom;
      return w;
   endfunction

   task automatic queue_word(sdoc_pkg::action_type act, sdoc_pkg::req_word_type w);
      req_item_type it;
      it.action = act;
      it.word   = w;
      pending_words.push_back(it);
      gen_count++;
   endtask

   task automatic queue_start(sdoc_pkg::action_type act, logic [15:0] idx, logic [7:0] sub,
                              logic [31:0] val);
      sdoc_pkg::req_word_type w;
      w = random_word();
      w.obj_index    = idx;
      w.obj_subindex = sub;
      w.write_value  = val;
      queue_word(act, w);
   endtask

   task automatic queue_frame(logic [10:0] id, logic [7:0] cmd, logic [15:0] idx,
                              logic [7:0] sub, logic [31:0] hi);
      sdoc_pkg::req_word_type w;
      w = random_word();
      w.rx_id   = id;
      w.rx_low  = {sub, idx, cmd};
      w.rx_high = hi;
      queue_word(sdoc_pkg::ACT_RX_FRAME, w);
   endtask

   task automatic queue_tick();
      queue_word(sdoc_pkg::ACT_TICK, random_word());
   endtask

   function automatic logic [7:0] read_ack_cmd();
      case ($urandom_range(0, 3))
         0: return sdoc_pkg::CMD_READ_ACK4;
         1: return sdoc_pkg::CMD_READ_ACK3;
         2: return sdoc_pkg::CMD_READ_ACK2;
         default: return sdoc_pkg::CMD_READ_ACK1;
      endcase
   endfunction

   // one corrupted or unrelated word during a transfer
   task automatic queue_disturbance(bit rd, logic [15:0] idx, logic [7:0] sub);
      logic [10:0] good_id;
      logic [10:0] bad_id;
      logic [7:0]  right_cmd;
      good_id   = sdoc_pkg::ID_RESP_BASE + 11'(gen_node);
      right_cmd = rd ? read_ack_cmd() : sdoc_pkg::CMD_WRITE_ACK;
      case ($urandom_range(0, 6))
         0: queue_tick();
         1: begin
            bad_id = 11'($urandom);
            if (bad_id == good_id)
               bad_id = bad_id ^ 11'h1;
            queue_frame(bad_id, right_cmd, idx, sub, $urandom);
         end
         2: queue_frame(good_id, 8'h80, idx, sub, $urandom);
         3: queue_frame(good_id, right_cmd, idx ^ (16'h1 << $urandom_range(0, 15)), sub,
                        $urandom);
         4: queue_frame(good_id, right_cmd, idx, sub ^ (8'h1 << $urandom_range(0, 7)),
                        $urandom);
         5: queue_frame(good_id, rd ? sdoc_pkg::CMD_WRITE_ACK : read_ack_cmd(), idx, sub,
                        $urandom);
         default: queue_word(sdoc_pkg::ACT_RX_FRAME, random_word());
      endcase
   endtask

   // start, some trouble, then an answer, silence or a run of ticks to give up
   task automatic queue_transfer();
      bit          rd;
      logic [15:0] idx;
      logic [7:0]  sub;
      int          tick_budget;
      int          pick;
      rd  = 1'($urandom_range(0, 1));
      idx = 16'($urandom);
      sub = 8'($urandom);
      case ($urandom_range(0, 7))
         0: idx = 16'h0000;
         1: idx = 16'hFFFF;
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0: sub = 8'h00;
         1: sub = 8'hFF;
         default: ;
      endcase
      if (rd)
         queue_start(sdoc_pkg::ACT_START_READ, idx, sub, $urandom);
      else
         queue_start(sdoc_pkg::ACT_START_WRITE, idx, sub, $urandom);
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 5)) queue_disturbance(rd, idx, sub);
      tick_budget = (gen_timeout == 0 ? 1 : gen_timeout) * (gen_limit == 0 ? 1 : gen_limit);
      pick = $urandom_range(0, 9);
      if (pick < 7)
         queue_frame(sdoc_pkg::ID_RESP_BASE + 11'(gen_node),
                     rd ? read_ack_cmd() : sdoc_pkg::CMD_WRITE_ACK, idx, sub, $urandom);
      else if (pick < 9 && tick_budget <= 64)
         repeat (tick_budget) queue_tick();
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(int node, int timeout, int limit);
      write_csr(sdoc_pkg::CSR_NODE_ID, 8'(node));
      write_csr(sdoc_pkg::CSR_TIMEOUT_TICKS, 8'(timeout));
      write_csr(sdoc_pkg::CSR_MAX_ATTEMPTS, 8'(limit));
      gen_node    = node;
      gen_timeout = timeout;
      gen_limit   = limit;
      settings++;
   endtask

   // everything sent, answered, and the pipeline given time to settle
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_holding || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // stall watchdog
   // ------------------------------------------------------------------
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_results.size());
      $display("sdo_expedited_client verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   int phase_node[7]    = '{127, 1, 0, 42, 127, 0, 99};
   int phase_timeout[7] = '{255, 1, 0, 3, 2, 0, 7};
   int phase_limit[7]   = '{15, 1, 0, 4, 15, 0, 2};
   int phase_base;

   initial begin
      gen_node    = int'(sdoc_pkg::NODE_ID_RST);
      gen_timeout = int'(sdoc_pkg::TIMEOUT_TICKS_RST);
      gen_limit   = int'(sdoc_pkg::MAX_ATTEMPTS_RST);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: node 1, five ticks, five attempts
      queue_tick();
      queue_frame(11'h581, sdoc_pkg::CMD_WRITE_ACK, 16'h0000, 8'h00, 32'h0);
      queue_start(sdoc_pkg::ACT_START_WRITE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_frame(11'h581, sdoc_pkg::CMD_WRITE_ACK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_start(sdoc_pkg::ACT_START_READ, 16'h0000, 8'h00, 32'hFFFF_FFFF);
      queue_frame(11'h582, sdoc_pkg::CMD_READ_ACK4, 16'h0000, 8'h00, 32'h1);
      queue_frame(11'h581, 8'h80, 16'h0000, 8'h00, 32'h0601_0000);
      queue_frame(11'h581, sdoc_pkg::CMD_READ_ACK1, 16'h0000, 8'h01, 32'h2);
      queue_frame(11'h581, sdoc_pkg::CMD_READ_ACK2, 16'h0001, 8'h00, 32'h3);
      queue_frame(11'h581, sdoc_pkg::CMD_WRITE_ACK, 16'h0000, 8'h00, 32'h4);
      queue_start(sdoc_pkg::ACT_START_READ, 16'h1234, 8'h56, 32'h0);
      repeat (5) queue_tick();
      queue_frame(11'h581, sdoc_pkg::CMD_READ_ACK4, 16'h1234, 8'h56, 32'hFFFF_FFFF);
      queue_start(sdoc_pkg::ACT_START_WRITE, 16'hA5A5, 8'h5A, 32'h0);
      queue_start(sdoc_pkg::ACT_START_READ, 16'h2000, 8'h01, 32'hFFFF_FFFF);
      queue_frame(11'h581, sdoc_pkg::CMD_READ_ACK3, 16'h2000, 8'h01, 32'h0123_4567);
      wait_drained();

      // directed, node zero with zero timeout and zero attempt limit
      apply_settings(0, 0, 0);
      queue_start(sdoc_pkg::ACT_START_READ, 16'h1000, 8'h02, 32'h0);
      queue_tick();
      queue_start(sdoc_pkg::ACT_START_WRITE, 16'h6000, 8'h10, 32'h5555_AAAA);
      queue_frame(11'h580, sdoc_pkg::CMD_WRITE_ACK, 16'h6000, 8'h10, 32'h0);
      queue_start(sdoc_pkg::ACT_START_READ, 16'h1018, 8'h01, 32'h0);
      queue_frame(11'h580, sdoc_pkg::CMD_READ_ACK2, 16'h1018, 8'h01, 32'h8000_0001);
      wait_drained();

      // random transfers under several settings
      phase_node[5]    = $urandom_range(1, 127);
      phase_timeout[5] = $urandom_range(1, 6);
      phase_limit[5]   = $urandom_range(1, 6);
      for (int p = 0; p < 7; p++) begin
         apply_settings(phase_node[p], phase_timeout[p], phase_limit[p]);
         phase_base = gen_count;
         while (gen_count - phase_base < WORDS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0)
               queue_word(sdoc_pkg::action_type'($urandom_range(0, 3)), random_word());
            else
               queue_transfer();
         end
         wait_drained();
      end

      if (awaited_results.size() != 0)
         $error("%0d expected results never arrived", awaited_results.size());
      $display("%0d request words over %0d register settings, %0d results checked",
               words_in, settings, results_seen);
      $display("transfers finished: %0d acknowledged, %0d abandoned after retries",
               done_ok, gave_up);
      if (fail_count == 0 && awaited_results.size() == 0)
         $display("sdo_expedited_client verification clean");
      else
         $display("sdo_expedited_client verification failed");
      $finish;
   end

endmodule
